### hw/rtl/qee_pkg.sv
package qee_pkg;

    // Step counter width; holds any step cap up to 127.
    localparam int CNT_W = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_SUM,
        ST_MAG,
        ST_ISSUE
    } state_t;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [CNT_W-1:0] count;
    } step_cmd_t;

    // Quadrature AB state for a phase: 0,1,2,3 -> 0,1,3,2
    function automatic logic [1:0] gray_of_phase(input logic [1:0] ph);
        logic [1:0] g;
        case (ph)
            2'd0:    g = 2'd0;
            2'd1:    g = 2'd1;
            2'd2:    g = 2'd3;
            default: g = 2'd2;
        endcase
        return g;
    endfunction

endpackage

### hw/rtl/quadrature_encoder_emulator.sv
// Quadrature encoder emulator. Each input transaction carries an absolute
// signed angle with FRAC_BITS fraction bits per encoder count; the change from
// the previous angle plus the kept remainder gives a pulse count, truncated
// toward zero, and one Gray-coded AB state is sent per pulse (up to MAX_STEPS,
// tlast on the final one; extra pulses are dropped). No output is sent when the
// count is zero. After the accepting cycle a transaction passes through the
// sequencer states delta, remainder add and magnitude (all on the shared
// adder), then issue, and then emits one step per cycle while the output is
// not stalled; output stalls lengthen the step phase. The next angle is
// accepted once the last step has been loaded into the output register.
module quadrature_encoder_emulator #(
    parameter int MAX_STEPS   = 16,
    parameter int FRAC_BITS   = 8,
    parameter int ANGLE_WIDTH = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((ANGLE_WIDTH+7)/8)*8-1:0]    s_tdata,  // [ANGLE_WIDTH-1:0] angle
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,  // [1:0] gray_state
    output logic                                m_tlast
);
    import qee_pkg::*;

    step_cmd_t  cmd;
    logic       step_busy;
    logic [1:0] gray;

    qee_accum #(
        .MAX_STEPS  (MAX_STEPS),
        .FRAC_BITS  (FRAC_BITS),
        .ANGLE_WIDTH(ANGLE_WIDTH)
    ) u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .angle    (s_tdata[ANGLE_WIDTH-1:0]),
        .step_busy(step_busy),
        .cmd      (cmd)
    );

    qee_stepper u_stepper (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .busy     (step_busy),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_gray (gray),
        .out_last (m_tlast)
    );

    assign m_tdata = {6'b0, gray};

endmodule

### hw/rtl/qee_accum.sv
module qee_accum #(
    parameter int MAX_STEPS   = 16,
    parameter int FRAC_BITS   = 8,
    parameter int ANGLE_WIDTH = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ANGLE_WIDTH-1:0] angle,
    input  logic                   step_busy,
    output qee_pkg::step_cmd_t     cmd
);
    import qee_pkg::*;

    localparam int SW = ANGLE_WIDTH + 2;
    localparam logic [SW-1:0] FRAC_MASK = SW'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic [SW-1:0] MAX_SW    = SW'(MAX_STEPS);

    state_t state_reg, state_next;

    logic [ANGLE_WIDTH-1:0] angle_reg;
    logic [ANGLE_WIDTH-1:0] prev_reg;
    logic [ANGLE_WIDTH:0]   frac_reg;
    logic [SW-1:0]          acc_reg;
    logic                   neg_reg;

    // shared adder
    logic [SW-1:0] op_a, op_b, sum;
    logic          cin;
    logic          acc_en;

    logic [SW-1:0] pulses, left, left_neg;
    logic [CNT_W-1:0] count;

    assign sum = op_a + op_b + SW'(cin);

    assign pulses   = acc_reg >> FRAC_BITS;
    assign left     = acc_reg & FRAC_MASK;
    assign left_neg = ~left + SW'(1);
    assign count    = (pulses < MAX_SW) ? pulses[CNT_W-1:0] : CNT_W'(MAX_STEPS);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid && in_ready) state_next = ST_DELTA;
            ST_DELTA: state_next = ST_SUM;
            ST_SUM:   state_next = ST_MAG;
            ST_MAG:   state_next = ST_ISSUE;
            ST_ISSUE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        op_a      = acc_reg;
        op_b      = '0;
        cin       = 1'b0;
        acc_en    = 1'b0;
        cmd.start = 1'b0;
        cmd.neg   = neg_reg;
        cmd.count = count;
        unique case (state_reg)
            ST_IDLE:  in_ready = !step_busy;
            ST_DELTA: begin
                // angle - previous angle
                op_a   = {{2{angle_reg[ANGLE_WIDTH-1]}}, angle_reg};
                op_b   = ~{{2{prev_reg[ANGLE_WIDTH-1]}}, prev_reg};
                cin    = 1'b1;
                acc_en = 1'b1;
            end
            ST_SUM: begin
                op_b   = {frac_reg[ANGLE_WIDTH], frac_reg};
                acc_en = 1'b1;
            end
            ST_MAG: begin
                if (acc_reg[SW-1]) begin
                    op_a = ~acc_reg;
                    cin  = 1'b1;
                end
                acc_en = 1'b1;
            end
            ST_ISSUE: cmd.start = (pulses != '0);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            prev_reg  <= '0;
            frac_reg  <= '0;
            neg_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DELTA) prev_reg <= angle_reg;
            if (state_reg == ST_MAG) neg_reg <= acc_reg[SW-1];
            if (state_reg == ST_ISSUE)
                frac_reg <= neg_reg ? left_neg[ANGLE_WIDTH:0] : left[ANGLE_WIDTH:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) angle_reg <= angle;
        if (acc_en) acc_reg <= sum;
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> (state_reg == ST_IDLE && !step_busy))
        else $error("ready outside idle");

    a_issue_after_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> ($past(state_reg) == ST_MAG && cmd.count != '0))
        else $error("bad step command");

    a_frac_small: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ((neg_reg ? (~frac_reg + 1'b1) : frac_reg)
            <= (ANGLE_WIDTH+1)'(FRAC_MASK)))
        else $error("remainder out of range");

endmodule

### hw/rtl/qee_stepper.sv
module qee_stepper (
    input  logic               aclk,
    input  logic               aresetn,
    input  qee_pkg::step_cmd_t cmd,
    output logic               busy,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_gray,
    output logic               out_last
);
    import qee_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic             neg_reg;
    logic [1:0]       phase_reg, phase_next;
    logic             valid_reg;
    logic [1:0]       gray_reg;
    logic             last_reg;
    logic             advance;

    assign busy       = (count_reg != '0);
    assign advance    = busy && (!valid_reg || out_ready);
    assign phase_next = neg_reg ? phase_reg - 2'd1 : phase_reg + 2'd1;

    assign out_valid = valid_reg;
    assign out_gray  = gray_reg;
    assign out_last  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            neg_reg   <= 1'b0;
            phase_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.start && !busy) begin
                count_reg <= cmd.count;
                neg_reg   <= cmd.neg;
            end else if (advance) begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (advance) begin
                phase_reg <= phase_next;
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            gray_reg <= gray_of_phase(phase_next);
            last_reg <= (count_reg == CNT_W'(1));
        end
    end

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> !busy)
        else $error("step command while busy");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && count_reg == CNT_W'(1)) |=> (!busy && out_valid && out_last))
        else $error("last step mismatch");

    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (phase_reg == $past(phase_reg) + 2'd1
                  || phase_reg == $past(phase_reg) - 2'd1))
        else $error("phase jumped");

endmodule

### verif/quadrature_encoder_emulator_tb.sv
`timescale 1ns / 100ps

module quadrature_encoder_emulator_tb;

    localparam int MAX_STEPS   = 16;
    localparam int FRAC_BITS   = 8;
    localparam int ANGLE_WIDTH = 24;
    localparam int COUNT       = 1 << FRAC_BITS;   // angle units per encoder count
    localparam int IDLE_PCT    = 28;
    localparam int SINK_HOLD   = 300;
    localparam int DRAIN_WAIT  = 40;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [1:0] ab;
        logic       last;
    } ab_step_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [ANGLE_WIDTH-1:0] s_tdata;    // [23:0] angle
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;    // [1:0] gray_state
    logic                   m_tlast;

    // Predictor state
    longint                 last_angle;
    longint                 frac_rem;
    logic [1:0]             ab_phase;
    ab_step_t               steps_due[$];

    logic [ANGLE_WIDTH-1:0] cur_angle;
    bit                     src_gaps;
    bit                     sink_gaps;
    bit                     sink_hold_req;
    int                     errors;
    int                     steps_seen;

    quadrature_encoder_emulator #(
        .MAX_STEPS   (MAX_STEPS),
        .FRAC_BITS   (FRAC_BITS),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40) begin
            $display("ERROR @%0t: %s", $realtime, what);
        end
    endtask

    // Work out the AB steps caused by one accepted angle.
    task automatic predict_steps(input logic [ANGLE_WIDTH-1:0] raw);
        longint angle;
        longint sum;
        longint mag;
        longint pulses;
        longint left;
        bit     neg;
        int     n;
        ab_step_t st;
        angle = longint'($signed(raw));
        sum = frac_rem + (angle - last_angle);
        neg = (sum < 0);
        mag = neg ? -sum : sum;
        pulses = mag >> FRAC_BITS;
        left = mag & longint'(COUNT - 1);
        last_angle = angle;
        frac_rem = neg ? -left : left;
        n = (pulses < MAX_STEPS) ? int'(pulses) : MAX_STEPS;
        for (int k = 0; k < n; k++) begin
            ab_phase = neg ? ab_phase - 2'd1 : ab_phase + 2'd1;
            st.ab = ab_phase ^ (ab_phase >> 1);
            st.last = (k == n - 1);
            steps_due.push_back(st);
        end
    endtask

    task automatic send_angle(input logic [ANGLE_WIDTH-1:0] a);
        if (src_gaps) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= a;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cur_angle = a;
        predict_steps(a);
    endtask

    task automatic send_move(input int d);
        logic [ANGLE_WIDTH-1:0] nxt;
        nxt = cur_angle + d[ANGLE_WIDTH-1:0];
        send_angle(nxt);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (steps_due.size() != 0) @(posedge aclk);
    endtask

    // Extremes, no movement, remainder only, negative remainder,
    // truncation toward zero, exact cap and dropped pulses.
    task automatic test_directed();
        send_angle('0);
        send_move(COUNT - 1);
        send_move(1);
        send_move(3 * COUNT);
        send_move(-100);
        send_move(-300);
        send_move(16 * COUNT + 144);
        send_move(17 * COUNT);
        send_move(15 * COUNT + 10);
        send_move(-(COUNT + 1));
        send_move(-(16 * COUNT));
        send_move(-(17 * COUNT));
        send_angle(24'h7FFFFF);
        send_angle(24'h800000);
        send_angle(24'h7FFFFF);
        send_angle(24'h7FFFFF);
        send_angle(24'hFFFFFF);
        send_angle(24'h000000);
        send_move(-1);
        send_move(1);
        send_move(-(COUNT - 1));
        send_move(MAX_STEPS * COUNT - 1);
        wait_drained();
    endtask

    // Mostly short moves around the step cap, some sub-count moves,
    // standstill, and the odd jump anywhere in the range.
    task automatic test_random_moves(input int count);
        int sel;
        int d;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 5) begin
                send_angle(ANGLE_WIDTH'($urandom()));
            end else begin
                if (sel < 15) begin
                    d = 0;
                end else if (sel < 30) begin
                    d = int'($urandom_range(2 * COUNT - 2)) - (COUNT - 1);
                end else begin
                    d = int'($urandom_range(2 * 18 * COUNT)) - 18 * COUNT;
                end
                send_move(d);
            end
        end
        wait_drained();
    endtask

    task automatic test_full_rate(input int count);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        test_random_moves(count);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    // Receiver stops for a long while; large moves fill the block so its
    // input has to stall.
    task automatic test_backpressure(input int count);
        int d;
        sink_hold_req = 1'b1;
        for (int i = 0; i < count; i++) begin
            d = int'($urandom_range(20 * COUNT, 14 * COUNT));
            send_move($urandom_range(1) ? d : -d);
        end
        wait_drained();
    endtask

    // Receiver: random ready, plus a long hold-off on request.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold_req) begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD) @(posedge aclk);
                sink_hold_req = 1'b0;
            end else begin
                m_tready <= !(sink_gaps && ($urandom_range(99) < IDLE_PCT));
            end
        end
    end

    // Result checker
    initial begin
        ab_step_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                steps_seen++;
                if (steps_due.size() == 0) begin
                    report_mismatch($sformatf("step %0d unexpected: ab=%0d last=%0b",
                                              steps_seen, m_tdata[1:0], m_tlast));
                end else begin
                    want = steps_due.pop_front();
                    if (m_tdata[1:0] !== want.ab) begin
                        report_mismatch($sformatf("step %0d gray_state %0d, want %0d",
                                                  steps_seen, m_tdata[1:0], want.ab));
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch($sformatf("step %0d last %0b, want %0b",
                                                  steps_seen, m_tlast, want.last));
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
        $display("quadrature_encoder_emulator: mismatch");
        $finish;
    end

    initial begin
        errors        = 0;
        steps_seen    = 0;
        last_angle    = 0;
        frac_rem      = 0;
        ab_phase      = 2'd0;
        cur_angle     = '0;
        src_gaps      = 1'b1;
        sink_gaps     = 1'b1;
        sink_hold_req = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_moves(210);
        test_full_rate(60);
        test_backpressure(28);

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0 && steps_due.size() == 0) begin
            $display("quadrature_encoder_emulator: match");
        end else begin
            $display("quadrature_encoder_emulator: mismatch");
        end
        $finish;
    end

endmodule

### quadrature_encoder_emulator.f
hw/rtl/qee_pkg.sv
hw/rtl/qee_accum.sv
hw/rtl/qee_stepper.sv
hw/rtl/quadrature_encoder_emulator.sv
verif/quadrature_encoder_emulator_tb.sv
